### src/gcdp_pkg.sv
// Shared types and constants for the running gcd and prime count core.
// Holds the queue entry passed from the front to the back. No dependencies.
package gcdp_pkg;

    localparam int VALUE_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int FIFO_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_prime;
        logic               last;
    } t_item;

endpackage

### src/gcdp_front.sv
// Front part: takes input items and classifies them by trial division.
// One remainder bit per cycle against each divisor. Depends on gcdp_pkg.
module gcdp_front #(
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [gcdp_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_last,
    output logic                         o_full,
    output logic                         o_q_push,
    output gcdp_pkg::t_item              o_q_item,
    input  logic                         i_q_full
);
    import gcdp_pkg::*;

    localparam int W  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int DW = (W + 1) / 2 + 1;
    localparam int BW = $clog2(W);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_PUSH
    } t_state;

    t_state          r_state;
    logic [W-1:0]    r_value;
    logic            r_last;
    logic            r_prime;
    logic [DW-1:0]   r_d;
    logic [W:0]      r_sq;
    logic [DW-1:0]   r_rem;
    logic [BW-1:0]   r_bit;

    logic [DW:0]     rem_shift;
    logic [DW-1:0]   n_rem;

    always_comb begin
        rem_shift = {r_rem, r_value[r_bit]};
        if (rem_shift >= {1'b0, r_d}) begin
            n_rem = DW'(rem_shift - {1'b0, r_d});
        end else begin
            n_rem = rem_shift[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_push) begin
                        r_value <= i_value[W-1:0];
                        r_last  <= i_last;
                        r_d     <= DW'(2);
                        r_sq    <= (W+1)'(4);
                        if (i_value[W-1:0] < W'(2)) begin
                            r_prime <= 1'b0;
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_sq > {1'b0, r_value}) begin
                        r_prime <= 1'b1;
                        r_state <= S_PUSH;
                    end else begin
                        r_rem   <= '0;
                        r_bit   <= BW'(W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    if (r_bit == '0) begin
                        if (n_rem == '0) begin
                            r_prime <= 1'b0;
                            r_state <= S_PUSH;
                        end else begin
                            r_sq    <= r_sq + (W+1)'({r_d, 1'b1});
                            r_d     <= r_d + DW'(1);
                            r_state <= S_CHECK;
                        end
                    end else begin
                        r_bit <= r_bit - BW'(1);
                    end
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    assign o_full            = (r_state != S_IDLE);
    assign o_q_push          = (r_state == S_PUSH) && !i_q_full;
    assign o_q_item.value    = VALUE_W'(r_value);
    assign o_q_item.is_prime = r_prime;
    assign o_q_item.last     = r_last;

endmodule

### src/gcdp_fifo.sv
// Short queue of classified items between the front and the back.
// Register array with read and write pointers. Depends on gcdp_pkg.
module gcdp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gcdp_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output gcdp_pkg::t_item o_item,
    output logic            o_empty
);
    import gcdp_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_item          r_mem [FIFO_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### src/gcdp_back.sv
// Back part: folds each value into the running gcd with a binary gcd unit,
// updates the saturating prime count and holds the result register.
// Depends on gcdp_pkg.
module gcdp_back #(
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  gcdp_pkg::t_item              i_q_item,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic                         o_is_prime,
    output logic [gcdp_pkg::VALUE_W-1:0] o_running_gcd,
    output logic [gcdp_pkg::COUNT_W-1:0] o_prime_count,
    output logic                         o_set_done
);
    import gcdp_pkg::*;

    localparam int W  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int KW = $clog2(W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [W-1:0]       r_gcd;
    logic [COUNT_W-1:0] r_tally;
    logic [W-1:0]       r_x;
    logic [W-1:0]       r_y;
    logic [KW-1:0]      r_k;
    logic               r_prime;
    logic               r_last;
    logic               r_out_valid;

    logic [W-1:0]       gcd_res;
    logic [COUNT_W-1:0] n_tally;
    logic               slot_free;

    assign gcd_res   = (r_x | r_y) << r_k;
    assign n_tally   = (r_prime && r_tally != COUNT_MAX) ? r_tally + COUNT_W'(1) : r_tally;
    assign slot_free = !r_out_valid || i_pop;
    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty   = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gcd       <= '0;
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_x     <= r_gcd;
                        r_y     <= i_q_item.value[W-1:0];
                        r_k     <= '0;
                        r_prime <= i_q_item.is_prime;
                        r_last  <= i_q_item.last;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_x == '0 || r_y == '0) begin
                        r_state <= S_DONE;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x >= r_y) begin
                        r_x <= (r_x - r_y) >> 1;
                    end else begin
                        r_y <= (r_y - r_x) >> 1;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        o_is_prime    <= r_prime;
                        o_running_gcd <= VALUE_W'(gcd_res);
                        o_prime_count <= n_tally;
                        o_set_done    <= r_last;
                        if (r_last) begin
                            r_gcd   <= '0;
                            r_tally <= '0;
                        end else begin
                            r_gcd   <= gcd_res;
                            r_tally <= n_tally;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/gcd_reduce_and_prime_count_core.sv
// Top level of the running gcd and prime count core.
// Joins gcdp_front, gcdp_fifo and gcdp_back. Depends on gcdp_pkg.
//
//  channel  | handshake     | payload
//  ---------+---------------+----------------------------------------------
//  input    | i_push/o_full | i_value, i_last
//  result   | o_empty/i_pop | o_is_prime, o_running_gcd, o_prime_count,
//           |               | o_set_done
//
// Classifying one item runs a remainder loop in the front that yields one
// bit per cycle against each trial divisor; the binary gcd in the back
// overlaps with the front.
// Reset is synchronous; o_full is high for one cycle after reset.
// A waiting result holds on the result ports until popped; the front keeps
// taking items while the two-entry queue has room.
module gcd_reduce_and_prime_count_core #(
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [gcdp_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_last,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic                         o_is_prime,
    output logic [gcdp_pkg::VALUE_W-1:0] o_running_gcd,
    output logic [gcdp_pkg::COUNT_W-1:0] o_prime_count,
    output logic                         o_set_done
);
    import gcdp_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_item q_wr_item;
    t_item q_rd_item;

    gcdp_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_value  (i_value),
        .i_last   (i_last),
        .o_full   (o_full),
        .o_q_push (q_push),
        .o_q_item (q_wr_item),
        .i_q_full (q_full)
    );

    gcdp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_wr_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_rd_item),
        .o_empty (q_empty)
    );

    gcdp_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_item      (q_rd_item),
        .o_q_pop       (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_is_prime    (o_is_prime),
        .o_running_gcd (o_running_gcd),
        .o_prime_count (o_prime_count),
        .o_set_done    (o_set_done)
    );

endmodule

### src/gcdp_checker.sv
// Port-level checks for the running gcd and prime count core.
// Bound to gcd_reduce_and_prime_count_core; depends on gcdp_pkg.
module gcdp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_push,
    input logic                         o_full,
    input logic                         o_empty,
    input logic                         i_pop,
    input logic                         o_is_prime,
    input logic [gcdp_pkg::VALUE_W-1:0] o_running_gcd,
    input logic [gcdp_pkg::COUNT_W-1:0] o_prime_count,
    input logic                         o_set_done
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !o_full |=> o_full)
        else $error("input taken while an item is still being classified");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_running_gcd)
            && $stable(o_prime_count) && $stable(o_is_prime) && $stable(o_set_done))
        else $error("waiting result changed before transfer");

    a_prime_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_is_prime |-> o_prime_count != '0)
        else $error("prime result with zero count");

    a_prime_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_is_prime |-> o_running_gcd != '0)
        else $error("prime result with zero running gcd");

endmodule

bind gcd_reduce_and_prime_count_core gcdp_checker u_gcdp_checker (.*);
